### rtl/core/icc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icc_pkg
// Types, widths and helpers shared by the interval coverage counter.
// ----------------------------------------------------------------------------
package icc_pkg;

	localparam int SLOT_W            = 10;
	localparam int COUNT_W           = 16;
	localparam int ENTRY_W           = 17;
	localparam int CMP_W             = 17;
	localparam int TIME_SLOTS_DEF    = 1024;
	localparam int unsigned MAX_INTERVALS_DEF = 32'd65535;

	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};
	localparam logic [COUNT_W-1:0]        COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_e_t;

	typedef enum logic {
		ST_OK  = 1'b0,
		ST_ERR = 1'b1
	} status_t;

	typedef struct packed {
		op_e_t             op;
		logic [SLOT_W-1:0] start_slot;
		logic [SLOT_W-1:0] end_slot;
		logic [SLOT_W-1:0] point;
	} req_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] cover_count;
		status_t            status;
	} rsp_item_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD_RD,
		S_ADD_LO,
		S_ADD_HI,
		S_Q_RUN,
		S_Q_DRAIN,
		S_DONE
	} seq_state_t;

	function automatic logic signed [ENTRY_W-1:0] sat_inc(
		input logic signed [ENTRY_W-1:0] v
	);
		return (v == ENTRY_MAX) ? v : v + ENTRY_W'(1);
	endfunction

	function automatic logic signed [ENTRY_W-1:0] sat_dec(
		input logic signed [ENTRY_W-1:0] v
	);
		return (v == ENTRY_MIN) ? v : v - ENTRY_W'(1);
	endfunction

endpackage
`default_nettype wire

### rtl/core/icc_delta_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icc_delta_mem
// Difference store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module icc_delta_mem
	import icc_pkg::*;
#(
	parameter int DEPTH = TIME_SLOTS_DEF
) (
	input  wire  logic                             clk,
	input  wire  logic                             we,
	input  wire  logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire  logic signed [ENTRY_W-1:0]        wdata,
	input  wire  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic signed [ENTRY_W-1:0]              rdata
);

	logic signed [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/icc_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icc_seq
// Sequencer: clearing pass, read-modify-write of adds, prefix sum of queries.
// ----------------------------------------------------------------------------
module icc_seq
	import icc_pkg::*;
#(
	parameter int          TIME_SLOTS    = TIME_SLOTS_DEF,
	parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  wire  logic                               clk,
	input  wire  logic                               arst_n,
	input  wire  logic                               req_valid,
	input  wire  req_item_t                          req,
	output logic                                     req_ready,
	output logic                                     res_valid,
	output rsp_item_t                                res,
	input  wire  logic                               res_ready,
	output logic                                     mem_we,
	output logic [$clog2(TIME_SLOTS)-1:0]            mem_waddr,
	output logic signed [ENTRY_W-1:0]                mem_wdata,
	output logic [$clog2(TIME_SLOTS)-1:0]            mem_raddr,
	input  wire  logic signed [ENTRY_W-1:0]          mem_rdata
);

	localparam int ADDR_W = $clog2(TIME_SLOTS);
	localparam int SUM_W  = ENTRY_W + ADDR_W + 1;
	localparam int CNT_W  = $clog2(64'(MAX_INTERVALS) + 64'd1);
	localparam logic [CMP_W-1:0]  TS_C      = CMP_W'(TIME_SLOTS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TIME_SLOTS - 1);
	localparam logic [CNT_W-1:0]  MAX_C     = CNT_W'(MAX_INTERVALS);

	seq_state_t               state_q, state_d;
	logic [ADDR_W-1:0]        idx_q;
	logic [ADDR_W-1:0]        lo_addr_q;
	logic [ADDR_W-1:0]        hi_addr_q;
	logic                     hi_ok_q;
	logic [ADDR_W-1:0]        p_q;
	op_e_t                    op_q;
	logic                     err_q;
	logic [CNT_W-1:0]         icount_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     acc_en_s1;

	logic                     accept;
	logic                     add_bad;
	logic                     query_bad;
	logic                     req_bad;
	logic [SLOT_W:0]          end_next;
	logic [COUNT_W-1:0]       clamp;

	assign accept    = req_valid && req_ready;
	assign end_next  = {1'b0, req.end_slot} + (SLOT_W + 1)'(1);
	assign add_bad   = (req.start_slot > req.end_slot)
	                || (CMP_W'(req.end_slot) >= TS_C)
	                || (icount_q >= MAX_C);
	assign query_bad = CMP_W'(req.point) >= TS_C;
	assign req_bad   = (req.op == OP_ADD) ? add_bad : query_bad;

	always_comb begin
		if (acc_q[SUM_W-1]) begin
			clamp = '0;
		end else if (|acc_q[SUM_W-2:COUNT_W]) begin
			clamp = COUNT_MAX;
		end else begin
			clamp = acc_q[COUNT_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (idx_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req_bad) begin
						state_d = S_DONE;
					end else if (req.op == OP_ADD) begin
						state_d = S_ADD_RD;
					end else begin
						state_d = S_Q_RUN;
					end
				end
			end
			S_ADD_RD:  state_d = S_ADD_LO;
			S_ADD_LO:  state_d = hi_ok_q ? S_ADD_HI : S_DONE;
			S_ADD_HI:  state_d = S_DONE;
			S_Q_RUN: begin
				if (idx_q == p_q) begin
					state_d = S_Q_DRAIN;
				end
			end
			S_Q_DRAIN: state_d = S_DONE;
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready       = 1'b0;
		res_valid       = 1'b0;
		res.cover_count = '0;
		res.status      = err_q ? ST_ERR : ST_OK;
		mem_we          = 1'b0;
		mem_waddr       = idx_q;
		mem_wdata       = '0;
		mem_raddr       = idx_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				req_ready = 1'b1;
			end
			S_ADD_RD: begin
				mem_raddr = lo_addr_q;
			end
			S_ADD_LO: begin
				mem_we    = 1'b1;
				mem_waddr = lo_addr_q;
				mem_wdata = sat_inc(mem_rdata);
				mem_raddr = hi_addr_q;
			end
			S_ADD_HI: begin
				mem_we    = 1'b1;
				mem_waddr = hi_addr_q;
				mem_wdata = sat_dec(mem_rdata);
			end
			S_Q_RUN: begin
				mem_raddr = idx_q;
			end
			S_Q_DRAIN: begin
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (!err_q && op_q == OP_QUERY) begin
					res.cover_count = clamp;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			idx_q     <= '0;
			icount_q  <= '0;
			acc_en_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			acc_en_s1 <= (state_q == S_Q_RUN);
			if (state_q == S_CLEAR || state_q == S_Q_RUN) begin
				idx_q <= idx_q + ADDR_W'(1);
			end else if (accept) begin
				idx_q <= '0;
			end
			if (state_q == S_ADD_LO) begin
				icount_q <= icount_q + CNT_W'(1);
			end
		end
	end

	// item fields and running sum
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.op;
			err_q     <= req_bad;
			lo_addr_q <= ADDR_W'(req.start_slot);
			hi_addr_q <= ADDR_W'(end_next);
			hi_ok_q   <= CMP_W'(end_next) < TS_C;
			p_q       <= ADDR_W'(req.point);
			acc_q     <= '0;
		end else if (acc_en_s1) begin
			acc_q <= acc_q + SUM_W'(mem_rdata);
		end
	end

endmodule
`default_nettype wire

### rtl/core/interval_coverage_counter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_coverage_counter_unit
// Interval coverage counter over a difference store in one synchronous memory.
// Add: read-modify-writes on the store port, of the start slot and, when it
//   is in range, of the slot after the end. Errors skip the store.
// Query at point p: one store read per slot from zero to p.
// One item at a time; the next is taken from the cycle after result handoff.
// Reset: store cleared by a pass over all TIME_SLOTS slots, no item accepted.
// ----------------------------------------------------------------------------
module interval_coverage_counter_unit
	import icc_pkg::*;
#(
	parameter int          TIME_SLOTS    = TIME_SLOTS_DEF,
	parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  wire  logic      clk,
	input  wire  logic      arst_n,
	input  wire  logic      req_valid,
	output logic            req_ready,
	input  wire  req_item_t req,
	output logic            rsp_valid,
	input  wire  logic      rsp_ready,
	output rsp_item_t       rsp
);

	localparam int ADDR_W = $clog2(TIME_SLOTS);

	logic                      res_valid;
	logic                      res_ready;
	rsp_item_t                 res;
	logic                      mem_we;
	logic [ADDR_W-1:0]         mem_waddr;
	logic signed [ENTRY_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]         mem_raddr;
	logic signed [ENTRY_W-1:0] mem_rdata;
	logic                      rsp_valid_q;
	rsp_item_t                 rsp_q;

	icc_seq #(
		.TIME_SLOTS    (TIME_SLOTS),
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	icc_delta_mem #(
		.DEPTH (TIME_SLOTS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_ERR) |-> (rsp.cover_count == '0))
		else $error("error item carries a nonzero count");

	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !res_valid)
		else $error("request taken while a result is pending");

	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> !res_valid || !mem_we)
		else $error("store written after result handoff");

endmodule
`default_nettype wire

### tb/coverage_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_checker
// Watches both channels of the interval coverage counter. For every accepted
// request it computes the expected response from its own copy of the
// difference store, then compares each accepted response with the oldest one.
// ----------------------------------------------------------------------------
module coverage_checker
	import icc_pkg::*;
#(
	parameter int          TIME_SLOTS    = TIME_SLOTS_DEF,
	parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_item_t req,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_item_t rsp,
	output int        errors,
	output int        outstanding
);

	localparam int DELTA_HI = 65535;
	localparam int DELTA_LO = -65536;

	int              slot_delta [TIME_SLOTS];
	longint unsigned stored_intervals;
	rsp_item_t       expected_covers [$];
	int              err_tally;

	function automatic void bump_delta(input int slot, input int d);
		int v;
		v = slot_delta[slot] + d;
		if (v > DELTA_HI) v = DELTA_HI;
		if (v < DELTA_LO) v = DELTA_LO;
		slot_delta[slot] = v;
	endfunction

	function automatic rsp_item_t predict_coverage(input req_item_t it);
		rsp_item_t r;
		int        total;
		r.cover_count = '0;
		r.status      = ST_OK;
		if (it.op == OP_ADD) begin
			if (it.start_slot > it.end_slot || int'(it.end_slot) >= TIME_SLOTS ||
			    stored_intervals >= longint'(MAX_INTERVALS)) begin
				r.status = ST_ERR;
			end else begin
				bump_delta(int'(it.start_slot), 1);
				if (int'(it.end_slot) + 1 < TIME_SLOTS)
					bump_delta(int'(it.end_slot) + 1, -1);
				stored_intervals++;
			end
		end else begin
			if (int'(it.point) >= TIME_SLOTS) begin
				r.status = ST_ERR;
			end else begin
				total = 0;
				for (int i = 0; i <= int'(it.point); i++)
					total += slot_delta[i];
				if (total < 0) total = 0;
				if (total > int'(COUNT_MAX)) total = int'(COUNT_MAX);
				r.cover_count = total[COUNT_W-1:0];
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < TIME_SLOTS; i++)
				slot_delta[i] = 0;
			stored_intervals = 0;
			expected_covers.delete();
			err_tally = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_covers.size() == 0) begin
					$error("unexpected response: cover_count %0d, status %0d",
					       rsp.cover_count, rsp.status);
					err_tally++;
				end else begin
					want = expected_covers.pop_front();
					if (rsp.cover_count !== want.cover_count) begin
						$error("cover_count mismatch: expected %0d, actual %0d",
						       want.cover_count, rsp.cover_count);
						err_tally++;
					end
					if (rsp.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
						       want.status, rsp.status);
						err_tally++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_covers.insert(expected_covers.size(), predict_coverage(req));
			errors <= err_tally;
			outstanding <= expected_covers.size();
		end
	end

endmodule

### tb/interval_coverage_counter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_coverage_counter_unit_test
// Drives directed and random add/query requests into the coverage counter
// with random idling on both sides, a long response hold-off and a drain
// pause, then closes with one add and three queries. A checker module
// predicts and compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module interval_coverage_counter_unit_test;
	import icc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 580;
	localparam int QUIET_TAIL     = 60;
	localparam int DRAIN_CYCLES   = 1100;
	localparam int LAST_SLOT      = TIME_SLOTS_DEF - 1;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;
	int        errors;
	int        outstanding;
	bit        idle_en;
	bit        hold_rsp;
	int        quiet_cycles;

	interval_coverage_counter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	coverage_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic req_item_t mk(input op_e_t op, input int s, input int e,
	                                 input int p);
		req_item_t it;
		it.op         = op;
		it.start_slot = SLOT_W'(s);
		it.end_slot   = SLOT_W'(e);
		it.point      = SLOT_W'(p);
		return it;
	endfunction

	function automatic req_item_t random_item();
		req_item_t          it;
		logic [SLOT_W-1:0]  a;
		logic [SLOT_W-1:0]  b;
		int                 pick;
		it = mk(OP_ADD, $urandom_range(0, LAST_SLOT), $urandom_range(0, LAST_SLOT),
		        $urandom_range(0, LAST_SLOT));
		if ($urandom_range(0, 1) == 1) begin
			it.op = OP_QUERY;
			pick = $urandom_range(0, 9);
			if (pick == 0) it.point = '0;
			else if (pick == 1) it.point = SLOT_W'(LAST_SLOT);
		end else begin
			a    = SLOT_W'($urandom_range(0, LAST_SLOT));
			b    = SLOT_W'($urandom_range(0, LAST_SLOT));
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				it.start_slot = (a > b) ? a : b;
				it.end_slot   = (a > b) ? b : a;
			end else if (pick == 2) begin
				it.start_slot = a;
				it.end_slot   = SLOT_W'(LAST_SLOT);
			end else if (pick == 3) begin
				it.start_slot = a;
				it.end_slot   = a;
			end else begin
				it.start_slot = (a > b) ? b : a;
				it.end_slot   = (a > b) ? a : b;
			end
		end
		return it;
	endfunction

	task automatic put_item(input req_item_t it);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		idle_en   = 1'b1;
		hold_rsp  = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		put_item(mk(OP_QUERY, LAST_SLOT, LAST_SLOT, 0));
		put_item(mk(OP_QUERY, 0, 0, LAST_SLOT));
		put_item(mk(OP_ADD, 0, 0, LAST_SLOT));
		put_item(mk(OP_ADD, 0, LAST_SLOT, 0));
		put_item(mk(OP_ADD, LAST_SLOT, LAST_SLOT, LAST_SLOT));
		put_item(mk(OP_ADD, 1, LAST_SLOT - 1, 0));
		put_item(mk(OP_ADD, 5, 3, 0));
		put_item(mk(OP_ADD, LAST_SLOT, 0, LAST_SLOT));
		put_item(mk(OP_ADD, 512, 512, 0));
		put_item(mk(OP_QUERY, 0, 0, 0));
		put_item(mk(OP_QUERY, LAST_SLOT, 0, 1));
		put_item(mk(OP_QUERY, 0, LAST_SLOT, 511));
		put_item(mk(OP_QUERY, 0, 0, 512));
		put_item(mk(OP_QUERY, 0, 0, 513));
		put_item(mk(OP_QUERY, 0, 0, LAST_SLOT - 1));
		put_item(mk(OP_QUERY, LAST_SLOT, LAST_SLOT, LAST_SLOT));
		put_item(mk(OP_ADD, LAST_SLOT - 1, LAST_SLOT, 0));
		put_item(mk(OP_QUERY, 0, 0, LAST_SLOT));
		put_item(mk(OP_QUERY, 0, 0, LAST_SLOT - 1));
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 200) hold_rsp = 1'b1;
			if (n == 400) wait_drained();
			if (n == RANDOM_ITEMS - QUIET_TAIL) idle_en = 1'b0;
			put_item(random_item());
		end

		put_item(mk(OP_ADD, 3, 7, 0));
		put_item(mk(OP_QUERY, 0, 0, 0));
		put_item(mk(OP_QUERY, 0, 0, 511));
		put_item(mk(OP_QUERY, 0, 0, LAST_SLOT));

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
